@@ hw/rtl/tcc_pkg.sv @@
// Shared widths and constants of the 3D triangle circumcenter pipeline.
// No dependencies; used by triangle_circumcenter_3d and tcc_checker.
package tcc_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int OUT_BITS   = 32;
  localparam int CFG_BITS   = 32;

  // Quotient bits resolved by the divider; larger magnitudes saturate.
  localparam int QUO_BITS   = OUT_BITS - 1;

  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * DIFF_BITS;            // unsigned squared length
  localparam int MID_BITS   = SQ_BITS + 2;              // signed bb+cc-aa
  localparam int WT_BITS    = SQ_BITS + MID_BITS;       // signed weight
  localparam int TOT_BITS   = WT_BITS + 2;              // signed weight total
  localparam int NUM_BITS   = WT_BITS + COORD_BITS + 1; // signed numerator
  localparam int NMAG_BITS  = NUM_BITS + FRAC_BITS;     // scaled magnitude
  localparam int REM_BITS   = (NMAG_BITS > TOT_BITS + QUO_BITS) ?
                              NMAG_BITS : TOT_BITS + QUO_BITS;

  // Operand splits of the two wide products.
  localparam int SQ_SPLIT   = SQ_BITS / 2;
  localparam int SH_BITS    = SQ_BITS - SQ_SPLIT;
  localparam int MH_BITS    = MID_BITS - SQ_SPLIT;
  localparam int WT_SPLIT   = WT_BITS / 2;
  localparam int WH_BITS    = WT_BITS - WT_SPLIT;

  // Centroid: magnitude times reciprocal of 3, exact for all inputs.
  localparam int SUM_BITS    = COORD_BITS + 2;
  localparam int CMAG_BITS   = SUM_BITS - 1 + FRAC_BITS;
  localparam int RECIP_SHIFT = CMAG_BITS | 1;
  localparam int RECIP_BITS  = RECIP_SHIFT - 1;
  localparam logic [RECIP_BITS-1:0] RECIP3 =
    RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd1) / 64'd3);
  localparam int CQ_BITS     = CMAG_BITS + RECIP_BITS - RECIP_SHIFT;

  localparam int SAT_BITS = (CQ_BITS > OUT_BITS + 1) ? CQ_BITS : OUT_BITS + 1;
  localparam logic [OUT_BITS-1:0] SAT_POS = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic [OUT_BITS-1:0] SAT_NEG = {1'b1, {(OUT_BITS-1){1'b0}}};

  localparam logic [CFG_BITS-1:0] THRESH_RESET = CFG_BITS'(1);

  localparam int FRONT_STAGES = 10;
  localparam int LATENCY      = FRONT_STAGES + QUO_BITS + 1;

endpackage

@@ hw/rtl/triangle_circumcenter_3d.sv @@
// Top level: pipelined circumcenter of a 3D triangle, barycentric form.
// Depends on tcc_pkg.
//
// One triangle enters per clock when start is high; busy is always low, so
// every start is a transaction. Each triangle yields exactly one result on
// done_o, in start order. The pipeline is 10 arithmetic stages (differences,
// squares, side sums, weight factors, weight partial products, weights,
// weight-by-coordinate products, numerators, magnitudes, overflow and
// degeneracy test), then one stage per quotient bit of the three restoring
// dividers (31), then the output register. The receiver cannot stall; results
// are shown for one cycle. The threshold register takes writes whenever
// cfg_valid_i is high (cfg_ready_o is tied high) and must only change while
// the pipe is empty. Outputs: signed fixed point with FRAC_BITS fraction bits,
// truncated toward zero and saturated to 32 bits; a weight total of magnitude
// below the threshold, or zero, returns the centroid with well_formed_o low.
module triangle_circumcenter_3d (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [tcc_pkg::COORD_BITS-1:0] ax_i,
  input  logic signed [tcc_pkg::COORD_BITS-1:0] ay_i,
  input  logic signed [tcc_pkg::COORD_BITS-1:0] az_i,
  input  logic signed [tcc_pkg::COORD_BITS-1:0] bx_i,
  input  logic signed [tcc_pkg::COORD_BITS-1:0] by_i,
  input  logic signed [tcc_pkg::COORD_BITS-1:0] bz_i,
  input  logic signed [tcc_pkg::COORD_BITS-1:0] cx_i,
  input  logic signed [tcc_pkg::COORD_BITS-1:0] cy_i,
  input  logic signed [tcc_pkg::COORD_BITS-1:0] cz_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tcc_pkg::CFG_BITS-1:0]          cfg_data_i,
  output logic                                 done_o,
  output logic signed [tcc_pkg::OUT_BITS-1:0]   center_x_o,
  output logic signed [tcc_pkg::OUT_BITS-1:0]   center_y_o,
  output logic signed [tcc_pkg::OUT_BITS-1:0]   center_z_o,
  output logic                                 well_formed_o
);

  localparam int NSTG = tcc_pkg::FRONT_STAGES + tcc_pkg::QUO_BITS;
  // side v is opposite vertex v: it joins vertices Nx[v] and Nt[v]
  localparam int Nx [3] = '{1, 2, 0};
  localparam int Nt [3] = '{2, 0, 1};

  typedef struct packed {
    logic                                  deg;
    logic [2:0]                            neg;
    logic [2:0]                            ovf;
    logic [2:0][tcc_pkg::OUT_BITS-1:0]     cent;
  } side_t;

  function automatic logic [tcc_pkg::OUT_BITS-1:0] sat_out(
    input logic neg, input logic [tcc_pkg::SAT_BITS-1:0] mag);
    logic [tcc_pkg::SAT_BITS-1:0] lim;
    logic [tcc_pkg::OUT_BITS-1:0] r;
    lim = tcc_pkg::SAT_BITS'(1) << (tcc_pkg::OUT_BITS - 1);
    if (!neg) r = (mag >= lim) ? tcc_pkg::SAT_POS : mag[tcc_pkg::OUT_BITS-1:0];
    else      r = (mag > lim) ? tcc_pkg::SAT_NEG : -mag[tcc_pkg::OUT_BITS-1:0];
    return r;
  endfunction

  // ---------------- control ----------------
  logic                          accept;
  logic [NSTG-1:0]               vld_q;
  logic                          done_q;
  logic [tcc_pkg::CFG_BITS-1:0]  thr_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
      thr_q  <= tcc_pkg::THRESH_RESET;
    end else begin
      vld_q  <= {vld_q[NSTG-2:0], accept};
      done_q <= vld_q[NSTG-1];
      if (cfg_valid_i && cfg_ready_o) thr_q <= cfg_data_i;
    end
  end

  // ---------------- stage 1: differences, coordinate sums ----------------
  logic signed [tcc_pkg::COORD_BITS-1:0] pin  [3][3];
  logic signed [tcc_pkg::COORD_BITS-1:0] p_q  [1:6][3][3];
  logic signed [tcc_pkg::DIFF_BITS-1:0]  d1_q [3][3];
  logic signed [tcc_pkg::SUM_BITS-1:0]   sum1_q [3];

  assign pin[0][0] = ax_i;  assign pin[0][1] = ay_i;  assign pin[0][2] = az_i;
  assign pin[1][0] = bx_i;  assign pin[1][1] = by_i;  assign pin[1][2] = bz_i;
  assign pin[2][0] = cx_i;  assign pin[2][1] = cy_i;  assign pin[2][2] = cz_i;

  always_ff @(posedge clk_i) begin
    for (int v = 0; v < 3; v++) begin
      for (int k = 0; k < 3; k++) begin
        p_q[1][v][k] <= pin[v][k];
        d1_q[v][k]   <= tcc_pkg::DIFF_BITS'(pin[Nx[v]][k])
                      - tcc_pkg::DIFF_BITS'(pin[Nt[v]][k]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      sum1_q[k] <= tcc_pkg::SUM_BITS'(pin[0][k]) + tcc_pkg::SUM_BITS'(pin[1][k])
                 + tcc_pkg::SUM_BITS'(pin[2][k]);
    end
    for (int s = 2; s <= 6; s++) p_q[s] <= p_q[s-1];
  end

  // ---------------- stage 2: squares; centroid magnitude ----------------
  logic signed [tcc_pkg::SQ_BITS-1:0]    dsq    [3][3];
  logic signed [tcc_pkg::SQ_BITS-1:0]    sqt2_q [3][3];
  logic [tcc_pkg::SUM_BITS-1:0]          sabs   [3];
  logic [tcc_pkg::CMAG_BITS-1:0]         cmag2_q [3];
  logic [2:0]                            cneg2_q;

  always_comb begin
    for (int v = 0; v < 3; v++)
      for (int k = 0; k < 3; k++) dsq[v][k] = d1_q[v][k] * d1_q[v][k];
    for (int k = 0; k < 3; k++)
      sabs[k] = sum1_q[k][tcc_pkg::SUM_BITS-1] ? unsigned'(-sum1_q[k])
                                               : unsigned'(sum1_q[k]);
  end

  always_ff @(posedge clk_i) begin
    sqt2_q <= dsq;
    for (int k = 0; k < 3; k++) begin
      cmag2_q[k] <= tcc_pkg::CMAG_BITS'(sabs[k][tcc_pkg::SUM_BITS-2:0])
                    << tcc_pkg::FRAC_BITS;
      cneg2_q[k] <= sum1_q[k][tcc_pkg::SUM_BITS-1];
    end
  end

  // ---------------- stage 3: squared sides; centroid times 1/3 ----------------
  localparam int CPW = tcc_pkg::CMAG_BITS + tcc_pkg::RECIP_BITS;
  logic [tcc_pkg::SQ_BITS-1:0] sq3_q [3];
  logic [CPW-1:0]              cprod   [3];
  logic [CPW-1:0]              cprod3_q [3];
  logic [2:0]                  cneg3_q;

  always_comb begin
    for (int k = 0; k < 3; k++) cprod[k] = cmag2_q[k] * tcc_pkg::RECIP3;
  end

  always_ff @(posedge clk_i) begin
    for (int v = 0; v < 3; v++)
      sq3_q[v] <= unsigned'(sqt2_q[v][0]) + unsigned'(sqt2_q[v][1])
                + unsigned'(sqt2_q[v][2]);
    cprod3_q <= cprod;
    cneg3_q  <= cneg2_q;
  end

  // ---------------- stage 4: weight factors; centroid result ----------------
  // centroid rides alongside until the divider load at stage 10
  logic [tcc_pkg::SQ_BITS-1:0]         sq4_q [3];
  logic signed [tcc_pkg::MID_BITS-1:0] m4_q  [3];
  logic [2:0][tcc_pkg::OUT_BITS-1:0]   cent_q [4:tcc_pkg::FRONT_STAGES-1];

  always_ff @(posedge clk_i) begin
    for (int v = 0; v < 3; v++) begin
      sq4_q[v] <= sq3_q[v];
      m4_q[v]  <= tcc_pkg::MID_BITS'(sq3_q[Nx[v]]) + tcc_pkg::MID_BITS'(sq3_q[Nt[v]])
                - tcc_pkg::MID_BITS'(sq3_q[v]);
    end
    for (int k = 0; k < 3; k++)
      cent_q[4][k] <= sat_out(cneg3_q[k], tcc_pkg::SAT_BITS'(
                        cprod3_q[k][CPW-1:tcc_pkg::RECIP_SHIFT]));
    for (int s = 5; s < tcc_pkg::FRONT_STAGES; s++) cent_q[s] <= cent_q[s-1];
  end

  // ---------------- stage 5: weight partial products ----------------
  localparam int HHW = tcc_pkg::SH_BITS + 1 + tcc_pkg::MH_BITS;
  localparam int HLW = tcc_pkg::SH_BITS + 1 + tcc_pkg::SQ_SPLIT + 1;
  localparam int LHW = tcc_pkg::SQ_SPLIT + 1 + tcc_pkg::MH_BITS;
  localparam int LLW = 2 * (tcc_pkg::SQ_SPLIT + 1);
  logic signed [HHW-1:0] hh [3], hh5_q [3];
  logic signed [HLW-1:0] hl [3], hl5_q [3];
  logic signed [LHW-1:0] lh [3], lh5_q [3];
  logic signed [LLW-1:0] ll [3], ll5_q [3];

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      hh[v] = $signed({1'b0, sq4_q[v][tcc_pkg::SQ_BITS-1:tcc_pkg::SQ_SPLIT]})
            * $signed(m4_q[v][tcc_pkg::MID_BITS-1:tcc_pkg::SQ_SPLIT]);
      hl[v] = $signed({1'b0, sq4_q[v][tcc_pkg::SQ_BITS-1:tcc_pkg::SQ_SPLIT]})
            * $signed({1'b0, m4_q[v][tcc_pkg::SQ_SPLIT-1:0]});
      lh[v] = $signed({1'b0, sq4_q[v][tcc_pkg::SQ_SPLIT-1:0]})
            * $signed(m4_q[v][tcc_pkg::MID_BITS-1:tcc_pkg::SQ_SPLIT]);
      ll[v] = $signed({1'b0, sq4_q[v][tcc_pkg::SQ_SPLIT-1:0]})
            * $signed({1'b0, m4_q[v][tcc_pkg::SQ_SPLIT-1:0]});
    end
  end

  always_ff @(posedge clk_i) begin
    hh5_q <= hh;
    hl5_q <= hl;
    lh5_q <= lh;
    ll5_q <= ll;
  end

  // ---------------- stage 6: weights ----------------
  logic signed [tcc_pkg::WT_BITS-1:0] wt6_q [3];

  always_ff @(posedge clk_i) begin
    for (int v = 0; v < 3; v++)
      wt6_q[v] <= (tcc_pkg::WT_BITS'(hh5_q[v]) <<< (2 * tcc_pkg::SQ_SPLIT))
                + (tcc_pkg::WT_BITS'(hl5_q[v]) <<< tcc_pkg::SQ_SPLIT)
                + (tcc_pkg::WT_BITS'(lh5_q[v]) <<< tcc_pkg::SQ_SPLIT)
                + tcc_pkg::WT_BITS'(ll5_q[v]);
  end

  // ---------------- stage 7: total; weight times coordinate ----------------
  localparam int PLW = tcc_pkg::WT_SPLIT + 1 + tcc_pkg::COORD_BITS;
  localparam int PHW = tcc_pkg::WH_BITS + tcc_pkg::COORD_BITS;
  logic signed [tcc_pkg::TOT_BITS-1:0] tot7_q;
  logic signed [PLW-1:0] plo [3][3], plo7_q [3][3];
  logic signed [PHW-1:0] phi [3][3], phi7_q [3][3];

  always_comb begin
    for (int v = 0; v < 3; v++)
      for (int k = 0; k < 3; k++) begin
        plo[v][k] = $signed({1'b0, wt6_q[v][tcc_pkg::WT_SPLIT-1:0]}) * p_q[6][v][k];
        phi[v][k] = $signed(wt6_q[v][tcc_pkg::WT_BITS-1:tcc_pkg::WT_SPLIT])
                  * p_q[6][v][k];
      end
  end

  always_ff @(posedge clk_i) begin
    tot7_q <= tcc_pkg::TOT_BITS'(wt6_q[0]) + tcc_pkg::TOT_BITS'(wt6_q[1])
            + tcc_pkg::TOT_BITS'(wt6_q[2]);
    plo7_q <= plo;
    phi7_q <= phi;
  end

  // ---------------- stage 8: numerators ----------------
  logic signed [tcc_pkg::NUM_BITS-1:0] num8_q [3];
  logic signed [tcc_pkg::TOT_BITS-1:0] tot8_q;

  always_ff @(posedge clk_i) begin
    tot8_q <= tot7_q;
    for (int k = 0; k < 3; k++)
      num8_q[k] <= (tcc_pkg::NUM_BITS'(phi7_q[0][k]) <<< tcc_pkg::WT_SPLIT)
                 + (tcc_pkg::NUM_BITS'(phi7_q[1][k]) <<< tcc_pkg::WT_SPLIT)
                 + (tcc_pkg::NUM_BITS'(phi7_q[2][k]) <<< tcc_pkg::WT_SPLIT)
                 + tcc_pkg::NUM_BITS'(plo7_q[0][k]) + tcc_pkg::NUM_BITS'(plo7_q[1][k])
                 + tcc_pkg::NUM_BITS'(plo7_q[2][k]);
  end

  // ---------------- stage 9: magnitudes and signs ----------------
  logic [tcc_pkg::NUM_BITS-1:0]  nabs [3];
  logic [tcc_pkg::NMAG_BITS-1:0] nmag9_q [3];
  logic [2:0]                    nneg9_q;
  logic [tcc_pkg::TOT_BITS-1:0]  tabs9_q;
  logic                          tneg9_q;

  always_comb begin
    for (int k = 0; k < 3; k++)
      nabs[k] = num8_q[k][tcc_pkg::NUM_BITS-1] ? unsigned'(-num8_q[k])
                                               : unsigned'(num8_q[k]);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      nmag9_q[k] <= tcc_pkg::NMAG_BITS'(nabs[k]) << tcc_pkg::FRAC_BITS;
      nneg9_q[k] <= num8_q[k][tcc_pkg::NUM_BITS-1];
    end
    tabs9_q <= tot8_q[tcc_pkg::TOT_BITS-1] ? unsigned'(-tot8_q) : unsigned'(tot8_q);
    tneg9_q <= tot8_q[tcc_pkg::TOT_BITS-1];
  end

  // ---------------- stage 10: overflow / degenerate test, divider load ----------------
  logic [tcc_pkg::REM_BITS-1:0] dv_rem_q [tcc_pkg::QUO_BITS+1][3];
  logic [tcc_pkg::QUO_BITS-1:0] dv_quo_q [tcc_pkg::QUO_BITS+1][3];
  logic [tcc_pkg::TOT_BITS-1:0] dv_d_q   [tcc_pkg::QUO_BITS+1];
  side_t                        dv_side_q [tcc_pkg::QUO_BITS+1];
  logic [tcc_pkg::REM_BITS-1:0] dlim;

  // quotient of 2^31 or more saturates either way
  assign dlim = tcc_pkg::REM_BITS'(tabs9_q) << tcc_pkg::QUO_BITS;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      dv_rem_q[0][k]     <= tcc_pkg::REM_BITS'(nmag9_q[k]);
      dv_quo_q[0][k]     <= '0;
      dv_side_q[0].ovf[k] <= tcc_pkg::REM_BITS'(nmag9_q[k]) >= dlim;
      dv_side_q[0].neg[k] <= nneg9_q[k] ^ tneg9_q;
    end
    dv_d_q[0]         <= tabs9_q;
    dv_side_q[0].deg  <= (tabs9_q == '0) || (tabs9_q < tcc_pkg::TOT_BITS'(thr_q));
    dv_side_q[0].cent <= cent_q[tcc_pkg::FRONT_STAGES-1];
  end

  // ---------------- restoring dividers, one quotient bit per stage ----------------
  for (genvar j = 0; j < tcc_pkg::QUO_BITS; j++) begin : g_div
    localparam int Bit = tcc_pkg::QUO_BITS - 1 - j;
    logic [tcc_pkg::REM_BITS-1:0] trial;

    assign trial = tcc_pkg::REM_BITS'(dv_d_q[j]) << Bit;

    always_ff @(posedge clk_i) begin
      for (int k = 0; k < 3; k++) begin
        if (dv_rem_q[j][k] >= trial) begin
          dv_rem_q[j+1][k] <= dv_rem_q[j][k] - trial;
          dv_quo_q[j+1][k] <= dv_quo_q[j][k] | (tcc_pkg::QUO_BITS'(1) << Bit);
        end else begin
          dv_rem_q[j+1][k] <= dv_rem_q[j][k];
          dv_quo_q[j+1][k] <= dv_quo_q[j][k];
        end
      end
      dv_d_q[j+1]    <= dv_d_q[j];
      dv_side_q[j+1] <= dv_side_q[j];
    end
  end

  // ---------------- output register ----------------
  logic [tcc_pkg::OUT_BITS-1:0] res [3];
  logic [tcc_pkg::OUT_BITS-1:0] res_q [3];
  logic                         wf_q;
  side_t                        fin;

  assign fin = dv_side_q[tcc_pkg::QUO_BITS];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (fin.deg)
        res[k] = fin.cent[k];
      else if (fin.ovf[k])
        res[k] = fin.neg[k] ? tcc_pkg::SAT_NEG : tcc_pkg::SAT_POS;
      else
        res[k] = sat_out(fin.neg[k],
                         tcc_pkg::SAT_BITS'(dv_quo_q[tcc_pkg::QUO_BITS][k]));
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res;
    wf_q  <= ~fin.deg;
  end

  assign done_o        = done_q;
  assign center_x_o    = res_q[0];
  assign center_y_o    = res_q[1];
  assign center_z_o    = res_q[2];
  assign well_formed_o = wf_q;

endmodule

@@ hw/rtl/tcc_checker.sv @@
// Port-level checks of triangle_circumcenter_3d, bound to the top level.
// Depends on tcc_pkg.
module tcc_assert (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic cfg_ready_o,
  input logic done_o
);

  // every start is taken, configuration always ready
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && cfg_ready_o)
    else $error("busy or config stall seen");

  // each transaction returns exactly at the pipeline latency
  a_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(tcc_pkg::LATENCY) done_o)
    else $error("result missing at pipeline latency");

  // no result without a transaction that latency ago
  a_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, tcc_pkg::LATENCY))
    else $error("result without matching transaction");

endmodule

bind triangle_circumcenter_3d tcc_assert u_tcc_assert (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .cfg_ready_o (cfg_ready_o),
  .done_o      (done_o)
);
